/* src/mmio_rtc_and_serial_port_core_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the RTC and serial port core
// Clocked implication checks with an asynchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef MMIO_RTC_AND_SERIAL_PORT_CORE_MACROS_SVH
`define MMIO_RTC_AND_SERIAL_PORT_CORE_MACROS_SVH

// same-cycle implication
`define MRTC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MRTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/mrtc_pkg.sv */
// ---------------------------------------------------------------------------
// mrtc_pkg
// Shared constants and types of the RTC and serial port core.
// ---------------------------------------------------------------------------
package mrtc_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned COUNT_W = 64;
	localparam int unsigned CHAR_W = 8;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned CFG_IDX_W = 1;

	// item kinds; code 3 is unused and reports an error
	localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RTC_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_ADDR = 1'd1;

	localparam logic [WORD_W-1:0] RTC_BASE_RST = 32'hA000_0048;
	localparam logic [WORD_W-1:0] SERIAL_ADDR_RST = 32'hA000_03F8;
	localparam logic [WORD_W-1:0] SERIAL_MASK = 32'h0000_00FF;

	// counter update request from the decoder
	typedef struct packed {
		logic              tick;
		logic              wr_lo;
		logic              wr_hi;
		logic [WORD_W-1:0] mask;
		logic [WORD_W-1:0] data;
	} cnt_upd_t;

	// one result item
	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic              status;
		logic              char_valid;
		logic [CHAR_W-1:0] char_out;
	} result_t;

	function automatic logic [WORD_W-1:0] merge_bits(
		input logic [WORD_W-1:0] old_w,
		input logic [WORD_W-1:0] mask,
		input logic [WORD_W-1:0] data
	);
		return (old_w & ~mask) | (data & mask);
	endfunction

endpackage

/* src/mrtc_decode.sv */
// ---------------------------------------------------------------------------
// mrtc_decode
// Address decode of one item: read data, status, serial char, counter update.
// ---------------------------------------------------------------------------
module mrtc_decode (
	input  logic [mrtc_pkg::KIND_W-1:0]  kind,
	input  logic [mrtc_pkg::WORD_W-1:0]  addr,
	input  logic [mrtc_pkg::WORD_W-1:0]  write_bits,
	input  logic [mrtc_pkg::WORD_W-1:0]  write_data,
	input  logic [mrtc_pkg::WORD_W-1:0]  rtc_base,
	input  logic [mrtc_pkg::WORD_W-1:0]  serial_addr,
	input  logic [mrtc_pkg::COUNT_W-1:0] time_count,
	output mrtc_pkg::result_t            result,
	output mrtc_pkg::cnt_upd_t           upd
);
	import mrtc_pkg::*;

	logic [WORD_W-1:0] offset;
	logic              in_window;
	logic              serial_hit;

	// window wraps modulo 2^32
	assign offset = addr - rtc_base;
	assign in_window = (offset[WORD_W-1:3] == '0);
	assign serial_hit = (addr == serial_addr);

	always_comb begin
		result = '0;
		upd = '0;
		upd.mask = write_bits;
		upd.data = write_data;
		case (kind)
			KIND_TICK: begin
				upd.tick = 1'b1;
			end
			KIND_READ: begin
				if (in_window) begin
					result.read_data = (offset == '0) ? time_count[WORD_W-1:0]
						: time_count[COUNT_W-1:WORD_W];
				end else begin
					result.status = 1'b1;
				end
			end
			KIND_WRITE: begin
				if (in_window) begin
					upd.wr_lo = !offset[2];
					upd.wr_hi = offset[2];
				end else if (serial_hit && write_bits == SERIAL_MASK) begin
					result.char_valid = 1'b1;
					result.char_out = write_data[CHAR_W-1:0];
				end else begin
					result.status = 1'b1;
				end
			end
			default: begin
				result.status = 1'b1;
			end
		endcase
	end

endmodule

/* src/mrtc_counter.sv */
// ---------------------------------------------------------------------------
// mrtc_counter
// 64-bit microsecond counter with tick and masked word writes.
// ---------------------------------------------------------------------------
module mrtc_counter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         upd_en,
	input  mrtc_pkg::cnt_upd_t           upd,
	output logic [mrtc_pkg::COUNT_W-1:0] time_count
);
	import mrtc_pkg::*;

	logic [COUNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (upd_en) begin
			if (upd.tick) begin
				count_q <= count_q + COUNT_W'(1);
			end else if (upd.wr_lo) begin
				count_q[WORD_W-1:0] <= merge_bits(count_q[WORD_W-1:0], upd.mask, upd.data);
			end else if (upd.wr_hi) begin
				count_q[COUNT_W-1:WORD_W] <=
					merge_bits(count_q[COUNT_W-1:WORD_W], upd.mask, upd.data);
			end
		end
	end

	assign time_count = count_q;

endmodule

/* src/mmio_rtc_and_serial_port_core.sv */
// ---------------------------------------------------------------------------
// mmio_rtc_and_serial_port_core
// Memory-mapped 64-bit microsecond clock with a byte-wide serial output.
// ---------------------------------------------------------------------------
//  channel   | direction | tdata (low bit up)                    | tuser
//  s_axis    | in        | addr, write_bits, write_data (96 b)   | kind
//  m_axis    | out       | read_data, char_out (40 b)            | status, char_valid
//  cfg       | in        | cfg_index 0 rtc_base, 1 serial_addr   | -
//
// One item per cycle sustained while the output is not stalled; each item passes through the input
// register and then sits in the result register until taken.
// The counter is read and updated in the same cycle an item leaves the
// input register, so back-to-back items see each other's effect.
// A stalled output holds the result register and then the input register.
// Reset clears the counter and valid flags and restores the two addresses.
module mmio_rtc_and_serial_port_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [95:0]                    s_axis_tdata,  // addr, write_bits, write_data
	input  logic [mrtc_pkg::KIND_W-1:0]    s_axis_tuser,  // kind
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [39:0]                    m_axis_tdata,  // read_data, char_out
	output logic [1:0]                     m_axis_tuser,  // status, char_valid
	input  logic                           cfg_we,
	input  logic [mrtc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mrtc_pkg::WORD_W-1:0]    cfg_data
);
	import mrtc_pkg::*;

	logic [WORD_W-1:0]  rtc_base_q;
	logic [WORD_W-1:0]  serial_addr_q;
	logic               valid_s1;
	logic [KIND_W-1:0]  kind_s1;
	logic [WORD_W-1:0]  addr_s1;
	logic [WORD_W-1:0]  bits_s1;
	logic [WORD_W-1:0]  data_s1;
	logic               out_valid_q;
	result_t            res_q;
	result_t            res_next;
	cnt_upd_t           upd;
	logic [COUNT_W-1:0] time_count;
	logic               advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtc_base_q <= RTC_BASE_RST;
			serial_addr_q <= SERIAL_ADDR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RTC_BASE: rtc_base_q <= cfg_data;
				CFG_SERIAL_ADDR: serial_addr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// s1 moves on when the result register is free or being emptied
	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1 <= s_axis_tuser;
			addr_s1 <= s_axis_tdata[31:0];
			bits_s1 <= s_axis_tdata[63:32];
			data_s1 <= s_axis_tdata[95:64];
		end
	end

	mrtc_decode u_decode (
		.kind        (kind_s1),
		.addr        (addr_s1),
		.write_bits  (bits_s1),
		.write_data  (data_s1),
		.rtc_base    (rtc_base_q),
		.serial_addr (serial_addr_q),
		.time_count  (time_count),
		.result      (res_next),
		.upd         (upd)
	);

	mrtc_counter u_counter (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd_en     (advance),
		.upd        (upd),
		.time_count (time_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {res_q.char_out, res_q.read_data};
	assign m_axis_tuser = {res_q.char_valid, res_q.status};

	`include "mmio_rtc_and_serial_port_core_macros.svh"

	`MRTC_ASSERT_SAME(a_char_no_err, clk, arst_n, out_valid_q && res_q.char_valid,
		!res_q.status, "serial char sent with error status")
	`MRTC_ASSERT_NEXT(a_tick_inc, clk, arst_n, advance && kind_s1 == KIND_TICK,
		time_count == $past(time_count) + COUNT_W'(1), "tick did not advance counter")
	`MRTC_ASSERT_NEXT(a_err_no_upd, clk, arst_n, advance && res_next.status,
		$stable(time_count), "error item changed the counter")
	`MRTC_ASSERT_NEXT(a_rd_zero, clk, arst_n, advance && kind_s1 != KIND_READ,
		out_valid_q && res_q.read_data == '0, "non-read item returned data")
	`MRTC_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(addr_s1), "stalled input stage lost its item")

endmodule

/* sim/mmio_rtc_and_serial_port_core_checker.sv */
// ---------------------------------------------------------------------------
// mmio_rtc_and_serial_port_core_checker
// Watches the input, output and register write channels of the RTC and
// serial port core. It keeps its own copy of the 64-bit counter and the
// address map, predicts the response of every accepted access and compares
// each response item field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module mmio_rtc_and_serial_port_core_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [95:0]                    s_axis_tdata,  // addr, write_bits, write_data
	input  logic [mrtc_pkg::KIND_W-1:0]    s_axis_tuser,  // kind
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [39:0]                    m_axis_tdata,  // read_data, char_out
	input  logic [1:0]                     m_axis_tuser,  // status, char_valid
	input  logic                           cfg_we,
	input  logic [mrtc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mrtc_pkg::WORD_W-1:0]    cfg_data,
	output int                             pending,
	output int                             fail_count,
	output int                             results_checked,
	output int                             chars_sent,
	output int                             error_responses
);
	import mrtc_pkg::*;

	localparam logic [WORD_W-1:0] WINDOW_BYTES = 32'd8;
	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		result_t            res;
		logic [COUNT_W-1:0] count;
	} access_outcome_t;

	logic [WORD_W-1:0]  rtc_base_q;
	logic [WORD_W-1:0]  serial_addr_q;
	logic [COUNT_W-1:0] time_count_q;
	result_t            expected_responses[$];
	result_t            observed;
	result_t            oldest;
	access_outcome_t    outcome;
	int                 errors_seen = 0;

	assign fail_count = errors_seen;

	// response of one access and the counter value it leaves behind
	function automatic access_outcome_t predict_access(
		input logic [KIND_W-1:0]  kind,
		input logic [WORD_W-1:0]  addr,
		input logic [WORD_W-1:0]  mask,
		input logic [WORD_W-1:0]  data,
		input logic [COUNT_W-1:0] count,
		input logic [WORD_W-1:0]  base,
		input logic [WORD_W-1:0]  serial
	);
		access_outcome_t o;
		logic [WORD_W-1:0] offset;
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] hi;
		logic              in_window;
		o = '0;
		o.count = count;
		o.res.status = STATUS_OK;
		// offset wraps mod 2^32, so a window at the top reaches address 0
		offset = addr - base;
		in_window = offset < WINDOW_BYTES;
		lo = count[WORD_W-1:0];
		hi = count[COUNT_W-1:WORD_W];
		case (kind)
			KIND_TICK: begin
				o.count = count + 1'b1;
			end
			KIND_READ: begin
				if (in_window) begin
					o.res.read_data = (offset == '0) ? lo : hi;
				end else begin
					o.res.status = STATUS_ERR;
				end
			end
			KIND_WRITE: begin
				// the window takes priority over an overlapping serial address
				if (in_window) begin
					if (offset[WORD_W-1:2] == '0) begin
						lo = (lo & ~mask) | (data & mask);
					end else begin
						hi = (hi & ~mask) | (data & mask);
					end
					o.count = {hi, lo};
				end else if (addr == serial && mask == SERIAL_MASK) begin
					o.res.char_valid = 1'b1;
					o.res.char_out = data[CHAR_W-1:0];
				end else begin
					o.res.status = STATUS_ERR;
				end
			end
			default: begin
				o.res.status = STATUS_ERR;
			end
		endcase
		return o;
	endfunction

	task automatic report_failure(input string msg);
		$display("[%0t] response %0d: %s", $time, results_checked, msg);
		errors_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtc_base_q = RTC_BASE_RST;
			serial_addr_q = SERIAL_ADDR_RST;
			time_count_q = '0;
			expected_responses.delete();
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				observed.read_data = m_axis_tdata[WORD_W-1:0];
				observed.char_out = m_axis_tdata[WORD_W +: CHAR_W];
				observed.status = m_axis_tuser[0];
				observed.char_valid = m_axis_tuser[1];
				if (expected_responses.size() == 0) begin
					report_failure("response item with nothing outstanding");
				end else begin
					oldest = expected_responses.pop_front();
					if (observed.read_data != oldest.read_data)
						report_failure($sformatf("read_data %h, want %h",
							observed.read_data, oldest.read_data));
					if (observed.status != oldest.status)
						report_failure($sformatf("status %b, want %b",
							observed.status, oldest.status));
					if (observed.char_valid != oldest.char_valid)
						report_failure($sformatf("char_valid %b, want %b",
							observed.char_valid, oldest.char_valid));
					if (observed.char_out != oldest.char_out)
						report_failure($sformatf("char_out %h, want %h",
							observed.char_out, oldest.char_out));
				end
				if (observed.char_valid)
					chars_sent++;
				if (observed.status == STATUS_ERR)
					error_responses++;
				results_checked++;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_RTC_BASE: rtc_base_q = cfg_data;
					CFG_SERIAL_ADDR: serial_addr_q = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				outcome = predict_access(s_axis_tuser, s_axis_tdata[31:0],
					s_axis_tdata[63:32], s_axis_tdata[95:64], time_count_q,
					rtc_base_q, serial_addr_q);
				time_count_q = outcome.count;
				expected_responses.push_back(outcome.res);
			end
			pending <= expected_responses.size();
		end
	end

endmodule

/* sim/mmio_rtc_and_serial_port_core_test.sv */
// ---------------------------------------------------------------------------
// mmio_rtc_and_serial_port_core_test
// Drives ticks, counter reads and writes, serial writes and unmapped
// accesses into the core under several address maps, with random gaps on
// both stream sides, and takes the verdict from the checker.
// ---------------------------------------------------------------------------
module mmio_rtc_and_serial_port_core_test;
	import mrtc_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int RESET_CYCLES = 11;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int TAIL_CYCLES = 10;
	localparam int MAP_COUNT = 7;
	localparam int ITEMS_PER_MAP = 100;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [95:0]          s_axis_tdata;  // addr, write_bits, write_data
	logic [KIND_W-1:0]    s_axis_tuser;  // kind
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [39:0]          m_axis_tdata;  // read_data, char_out
	logic [1:0]           m_axis_tuser;  // status, char_valid
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	int pending;
	int fail_count;
	int results_checked;
	int chars_sent;
	int error_responses;
	int cycle_count = 0;
	int items_sent = 0;
	int maps_used = 0;
	bit no_idle = 0;
	bit hold_sink = 0;

	mmio_rtc_and_serial_port_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	mmio_rtc_and_serial_port_core_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pending         (pending),
		.fail_count      (fail_count),
		.results_checked (results_checked),
		.chars_sent      (chars_sent),
		.error_responses (error_responses)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("mmio_rtc_and_serial_port_core_test: errors");
			$finish;
		end
	end

	// mostly no gap, some short, a few long
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(
		input logic [KIND_W-1:0] kind,
		input logic [WORD_W-1:0] addr,
		input logic [WORD_W-1:0] mask,
		input logic [WORD_W-1:0] data
	);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {data, mask, addr};
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// only called with nothing outstanding
	task automatic write_map(input logic [WORD_W-1:0] base, input logic [WORD_W-1:0] serial);
		cfg_we <= 1'b1;
		cfg_index <= CFG_RTC_BASE;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= CFG_SERIAL_ADDR;
		cfg_data <= serial;
		@(posedge clk);
		cfg_we <= 1'b0;
		maps_used++;
	endtask

	task automatic random_access(input logic [WORD_W-1:0] base, input logic [WORD_W-1:0] serial);
		logic [KIND_W-1:0] kind;
		logic [WORD_W-1:0] addr;
		logic [WORD_W-1:0] mask;
		logic [WORD_W-1:0] data;
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			kind = KIND_TICK;
		else if (r < 65)
			kind = KIND_READ;
		else if (r < 96)
			kind = KIND_WRITE;
		else
			kind = KIND_UNUSED;
		r = $urandom_range(0, 99);
		if (r < 45)
			addr = base + $urandom_range(0, 7);
		else if (r < 62)
			addr = serial;
		else if (r < 67)
			addr = base - $urandom_range(1, 4);
		else if (r < 72)
			addr = base + 32'd8 + $urandom_range(0, 3);
		else
			addr = $urandom;
		r = $urandom_range(0, 9);
		if (r < 3)
			mask = SERIAL_MASK;
		else if (r == 3)
			mask = '1;
		else if (r == 4)
			mask = '0;
		else if (r == 5)
			mask = 32'd1 << $urandom_range(0, 31);
		else
			mask = $urandom;
		// values just under a carry so ticks ripple into the high word
		if ($urandom_range(0, 4) == 0)
			data = 32'hFFFF_FFFF - $urandom_range(0, 3);
		else
			data = $urandom;
		send_item(kind, addr, mask, data);
	endtask

	// output side: random stalls, or one long hold-off on request
	initial begin
		int gap;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_sink) begin
				hold_sink = 0;
				gap = HOLD_OFF_CYCLES;
			end else begin
				gap = idle_length();
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	initial begin
		logic [WORD_W-1:0] base;
		logic [WORD_W-1:0] serial;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= KIND_TICK;
		cfg_we <= 1'b0;
		cfg_index <= CFG_RTC_BASE;
		cfg_data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset map, word selection, wrap, serial mask, unmapped
		base = RTC_BASE_RST;
		serial = SERIAL_ADDR_RST;
		send_item(KIND_READ, base, '0, '0);
		send_item(KIND_TICK, '0, '0, '0);
		send_item(KIND_READ, base, '0, '0);
		send_item(KIND_WRITE, base, '1, '1);
		send_item(KIND_WRITE, base + 32'd4, '1, '1);
		send_item(KIND_READ, base + 32'd1, '0, '0);
		send_item(KIND_READ, base + 32'd7, '0, '0);
		send_item(KIND_TICK, '1, '1, '1);
		send_item(KIND_READ, base, '0, '0);
		send_item(KIND_READ, base + 32'd4, '0, '0);
		send_item(KIND_WRITE, base + 32'd3, 32'h0000_FF00, 32'hA5A5_A5A5);
		send_item(KIND_WRITE, base + 32'd5, 32'h0F0F_0F0F, 32'h1234_5678);
		send_item(KIND_READ, base + 32'd8, '0, '0);
		send_item(KIND_READ, base - 32'd1, '0, '0);
		send_item(KIND_WRITE, base + 32'd8, '1, '1);
		send_item(KIND_WRITE, serial, SERIAL_MASK, 32'h0000_0041);
		send_item(KIND_WRITE, serial, SERIAL_MASK, '1);
		send_item(KIND_WRITE, serial, 32'h0000_01FF, 32'h0000_0042);
		send_item(KIND_WRITE, serial, '0, 32'h0000_0043);
		send_item(KIND_READ, serial, '0, '0);
		send_item(KIND_UNUSED, base, '1, '1);
		send_item(KIND_READ, base, '0, '0);
		wait_drained();

		// window at the top of the address space, serial address inside it
		write_map(32'hFFFF_FFFC, '0);
		send_item(KIND_READ, 32'hFFFF_FFFC, '0, '0);
		send_item(KIND_WRITE, '0, SERIAL_MASK, 32'h0000_0055);
		send_item(KIND_READ, 32'h0000_0003, '0, '0);
		send_item(KIND_READ, 32'h0000_0004, '0, '0);
		wait_drained();

		for (int m = 0; m < MAP_COUNT; m++) begin
			case (m)
				0: begin
					base = '0;
					serial = '1;
				end
				1: begin
					base = '1;
					serial = '0;
				end
				2: begin
					base = RTC_BASE_RST;
					serial = SERIAL_ADDR_RST;
				end
				4: begin
					base = $urandom;
					serial = base + 32'd2;
				end
				5: begin
					base = 32'hFFFF_FFF8;
					serial = $urandom;
				end
				default: begin
					base = $urandom;
					serial = $urandom;
				end
			endcase
			write_map(base, serial);
			no_idle = (m == 2);
			if (m == 3)
				hold_sink = 1;
			for (int n = 0; n < ITEMS_PER_MAP; n++) begin
				random_access(base, serial);
				if (m == 5 && n == ITEMS_PER_MAP / 2)
					wait_drained();
				else
					pause_sender(idle_length());
			end
			wait_drained();
		end
		no_idle = 0;

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d items under %0d address maps, %0d responses checked",
			items_sent, maps_used, results_checked);
		$display("%0d characters sent, %0d error responses", chars_sent, error_responses);
		if (fail_count == 0)
			$display("mmio_rtc_and_serial_port_core_test: clean");
		else
			$display("mmio_rtc_and_serial_port_core_test: errors");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/mrtc_pkg.sv
src/mrtc_decode.sv
src/mrtc_counter.sv
src/mmio_rtc_and_serial_port_core.sv
sim/mmio_rtc_and_serial_port_core_checker.sv
sim/mmio_rtc_and_serial_port_core_test.sv
